[rtl/assert_macros.svh]
// Assertion macros used by the keypad scanner top level.
// No dependencies; define SYNTH to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[rtl/kmds_pkg.sv]
// Shared constants, types and key map for the keypad matrix scanner.
// No dependencies.
package kmds_pkg;

   localparam int KEY_COUNT       = 16;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_WRAP_AT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_RESTART = 8'd1;

   localparam logic [3:0] SYMBOL_BASE = 4'd10;

   localparam logic [7:0] COUNT_WRAP_AT_RESET = 8'd4;
   localparam logic [7:0] COUNT_RESTART_RESET = 8'd1;

   typedef struct packed {
      logic [3:0] last_digit;
      logic [3:0] last_symbol;
      logic [7:0] digit_count;
      logic       digit_event;
      logic       symbol_event;
   } kmds_result_type;

   // Row-major key layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
   function automatic logic [3:0] key_value(input logic [3:0] key);
      logic [3:0] v;
      case (key)
         4'd0:    v = 4'd1;
         4'd1:    v = 4'd2;
         4'd2:    v = 4'd3;
         4'd3:    v = 4'd10;
         4'd4:    v = 4'd4;
         4'd5:    v = 4'd5;
         4'd6:    v = 4'd6;
         4'd7:    v = 4'd11;
         4'd8:    v = 4'd7;
         4'd9:    v = 4'd8;
         4'd10:   v = 4'd9;
         4'd11:   v = 4'd12;
         4'd12:   v = 4'd13;
         4'd13:   v = 4'd0;
         4'd14:   v = 4'd14;
         default: v = 4'd15;
      endcase
      return v;
   endfunction

endpackage

[rtl/keypad_matrix_debounce_scanner.sv]
// A req transaction passes the input register, then the result register, to rsp_valid.
// Throughput: one transaction per cycle, as long as rsp_ready does not hold it back.
// Reset (synchronous, active high): all key debouncers idle, digit counter and stores zero,
// count_wrap_at = 4, count_restart = 1, no transaction held in either register.
// Depends on kmds_pkg, kmds_key_debounce, kmds_event_merge and assert_macros.svh.
`include "assert_macros.svh"
module keypad_matrix_debounce_scanner (
   input  logic        clock,
   input  logic        reset,
   // scan tick input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_keys_pressed,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_last_digit,
   output logic [3:0]  rsp_last_symbol,
   output logic [7:0]  rsp_digit_count,
   output logic        rsp_digit_event,
   output logic        rsp_symbol_event,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [kmds_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   // Input register: holds one scan tick until the result register can take it.
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [15:0] keys_ff;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   kmds_pkg::kmds_result_type result_ff;
   kmds_pkg::kmds_result_type result_in;

   // Configuration registers.
   logic [7:0] wrap_at_ff;
   logic [7:0] wrap_at_in;
   logic [7:0] restart_ff;
   logic [7:0] restart_in;

   logic                            advance;
   logic [kmds_pkg::KEY_COUNT-1:0] fire;
   logic                            symbol_code_ok;

   // Advance the tick in the input register when the result slot is free or draining.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on transaction, no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         keys_ff <= req_keys_pressed;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // Write configuration only while idle (not enforced); accept all, drop unknown indexes.
   assign csr_ready = 1'b1;

   always_comb begin
      wrap_at_in = wrap_at_ff;
      restart_in = restart_ff;
      if (csr_valid) begin
         case (csr_index)
            kmds_pkg::CSR_COUNT_WRAP_AT: wrap_at_in = csr_wdata;
            kmds_pkg::CSR_COUNT_RESTART: restart_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_at_ff <= kmds_pkg::COUNT_WRAP_AT_RESET;
         restart_ff <= kmds_pkg::COUNT_RESTART_RESET;
      end else begin
         wrap_at_ff <= wrap_at_in;
         restart_ff <= restart_in;
      end
   end

   // One debouncer per key; all step together on each advanced tick.
   for (genvar g = 0; g < kmds_pkg::KEY_COUNT; g++) begin : g_key
      kmds_key_debounce u_key (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pressed (keys_ff[g]),
         .fire    (fire[g])
      );
   end

   // Priority merge, counter restart/advance and value stores.
   kmds_event_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fire    (fire),
      .wrap_at (wrap_at_ff),
      .restart (restart_ff),
      .result  (result_in)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_last_digit   = result_ff.last_digit;
   assign rsp_last_symbol  = result_ff.last_symbol;
   assign rsp_digit_count  = result_ff.digit_count;
   assign rsp_digit_event  = result_ff.digit_event;
   assign rsp_symbol_event = result_ff.symbol_event;

   assign symbol_code_ok = (result_ff.last_symbol >= kmds_pkg::SYMBOL_BASE);

   // A stored digit is always a decimal digit.
   `ASSERT_NEVER(a_digit_range, clock, reset, rsp_valid_ff && (result_ff.last_digit > 4'd9))
   // A symbol event always leaves a symbol code in the store.
   `ASSERT_IMPLY(a_symbol_code, clock, reset, rsp_valid_ff && result_ff.symbol_event, symbol_code_ok)
   // A tick waiting in the input register stays there until it advances.
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

[rtl/kmds_key_debounce.sv]
// Five-phase debouncer for one key of the matrix.
// Depends on nothing but the clock and reset.
module kmds_key_debounce (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic pressed,
   output logic fire
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ARMED   = 3'd1;
   localparam logic [2:0] PH_CONFIRM = 3'd2;
   localparam logic [2:0] PH_HELD    = 3'd3;
   localparam logic [2:0] PH_RELEASE = 3'd4;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE:    if (pressed) phase_in = PH_ARMED;
         PH_ARMED:   phase_in = pressed ? PH_CONFIRM : PH_IDLE;
         PH_CONFIRM: phase_in = pressed ? PH_HELD : PH_RELEASE;
         PH_HELD:    if (!pressed) phase_in = PH_RELEASE;
         PH_RELEASE: phase_in = pressed ? PH_HELD : PH_IDLE;
         default:    phase_in = phase_ff;  // unreachable codes hold
      endcase
   end

   assign fire = (phase_ff == PH_CONFIRM);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/kmds_event_merge.sv]
// Merges per-key fire flags into digit/symbol stores and the digit counter.
// Depends on kmds_pkg.
module kmds_event_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [kmds_pkg::KEY_COUNT-1:0] fire,
   input  logic [7:0]                wrap_at,
   input  logic [7:0]                restart,
   output kmds_pkg::kmds_result_type result
);

   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] symbol_ff;
   logic [3:0] symbol_in;
   logic [7:0] count_base;
   logic [4:0] digit_hits;
   logic       sym_hit;
   logic [3:0] value;

   always_comb begin
      count_base = (count_ff == wrap_at) ? restart : count_ff;
      digit_hits = 5'd0;
      sym_hit    = 1'b0;
      digit_in   = digit_ff;
      symbol_in  = symbol_ff;
      value      = 4'd0;
      // later keys in scan order overwrite earlier ones
      for (int k = 0; k < kmds_pkg::KEY_COUNT; k++) begin
         value = kmds_pkg::key_value(4'(k));
         if (fire[k]) begin
            if (value < kmds_pkg::SYMBOL_BASE) begin
               digit_in   = value;
               digit_hits = digit_hits + 5'd1;
            end else begin
               symbol_in = value;
               sym_hit   = 1'b1;
            end
         end
      end
      count_in = count_base + {3'b000, digit_hits};
   end

   assign result.last_digit   = digit_in;
   assign result.last_symbol  = symbol_in;
   assign result.digit_count  = count_in;
   assign result.digit_event  = (digit_hits != 5'd0);
   assign result.symbol_event = sym_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 8'd0;
         digit_ff  <= 4'd0;
         symbol_ff <= 4'd0;
      end else if (advance) begin
         count_ff  <= count_in;
         digit_ff  <= digit_in;
         symbol_ff <= symbol_in;
      end
   end

endmodule

[bench/kmds_checker.sv]
`timescale 1ns / 100ps
// Result checker for the keypad matrix scanner: watches the scan tick, result and
// register channels, predicts each result and compares it field by field.
// Depends on kmds_pkg for the result type, register indexes and the symbol base.
module kmds_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_keys_pressed,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_last_digit,
   input  logic [3:0]  rsp_last_symbol,
   input  logic [7:0]  rsp_digit_count,
   input  logic        rsp_digit_event,
   input  logic        rsp_symbol_event,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [kmds_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_ARMED, PH_FIRE, PH_HELD, PH_RELEASING
   } key_phase_type;

   localparam logic [3:0] SYM_A    = 4'd10;
   localparam logic [3:0] SYM_B    = 4'd11;
   localparam logic [3:0] SYM_C    = 4'd12;
   localparam logic [3:0] SYM_STAR = 4'd13;
   localparam logic [3:0] SYM_HASH = 4'd14;
   localparam logic [3:0] SYM_D    = 4'd15;

   // row-major: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
   localparam logic [3:0] KEY_CODE [kmds_pkg::KEY_COUNT] = '{
      4'd1, 4'd2, 4'd3, SYM_A,
      4'd4, 4'd5, 4'd6, SYM_B,
      4'd7, 4'd8, 4'd9, SYM_C,
      SYM_STAR, 4'd0, SYM_HASH, SYM_D
   };

   key_phase_type             phase_q [kmds_pkg::KEY_COUNT];
   logic [7:0]                count_q;
   logic [7:0]                wrap_at_q;
   logic [7:0]                restart_q;
   logic [3:0]                digit_q;
   logic [3:0]                symbol_q;
   int                        mismatches;
   kmds_pkg::kmds_result_type expected_q [$];

   // Advance all debouncers by one scan tick and return the resulting outputs.
   function automatic kmds_pkg::kmds_result_type scan_tick(input logic [15:0] keys);
      kmds_pkg::kmds_result_type r;
      logic                      fires;
      r = '0;
      if (count_q == wrap_at_q) count_q = restart_q;
      for (int k = 0; k < kmds_pkg::KEY_COUNT; k++) begin
         fires = 1'b0;
         case (phase_q[k])
            PH_IDLE:      if (keys[k]) phase_q[k] = PH_ARMED;
            PH_ARMED:     phase_q[k] = keys[k] ? PH_FIRE : PH_IDLE;
            PH_FIRE: begin
               fires = 1'b1;
               phase_q[k] = keys[k] ? PH_HELD : PH_RELEASING;
            end
            PH_HELD:      if (!keys[k]) phase_q[k] = PH_RELEASING;
            PH_RELEASING: phase_q[k] = keys[k] ? PH_HELD : PH_IDLE;
            default: ;
         endcase
         if (fires) begin
            if (KEY_CODE[k] < kmds_pkg::SYMBOL_BASE) begin
               digit_q = KEY_CODE[k];
               count_q = count_q + 8'd1;
               r.digit_event = 1'b1;
            end else begin
               symbol_q = KEY_CODE[k];
               r.symbol_event = 1'b1;
            end
         end
      end
      r.last_digit  = digit_q;
      r.last_symbol = symbol_q;
      r.digit_count = count_q;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      kmds_pkg::kmds_result_type want;
      if (reset) begin
         foreach (phase_q[k]) phase_q[k] = PH_IDLE;
         count_q    = '0;
         digit_q    = '0;
         symbol_q   = '0;
         wrap_at_q  = kmds_pkg::COUNT_WRAP_AT_RESET;
         restart_q  = kmds_pkg::COUNT_RESTART_RESET;
         mismatches = 0;
         expected_q.delete();
      end else begin
         // compare before predicting: a result can never belong to this edge's tick
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t ns: result transaction with no scan tick outstanding", $time);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("last_digit", int'(want.last_digit), int'(rsp_last_digit));
               check_field("last_symbol", int'(want.last_symbol), int'(rsp_last_symbol));
               check_field("digit_count", int'(want.digit_count), int'(rsp_digit_count));
               check_field("digit_event", int'(want.digit_event), int'(rsp_digit_event));
               check_field("symbol_event", int'(want.symbol_event),
                           int'(rsp_symbol_event));
            end
         end
         if (req_valid && req_ready) expected_q.push_back(scan_tick(req_keys_pressed));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kmds_pkg::CSR_COUNT_WRAP_AT: wrap_at_q = csr_wdata;
               kmds_pkg::CSR_COUNT_RESTART: restart_q = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
   end

endmodule

[bench/keypad_matrix_debounce_scanner_tb.sv]
`timescale 1ns / 100ps
// Top of the keypad scanner testbench: clock, reset, scan tick stimulus, register
// writes, result back-pressure and the verdict.
// Depends on kmds_pkg, the scanner RTL and kmds_checker.
module keypad_matrix_debounce_scanner_tb;

   localparam int CLOCK_HALF     = 6;     // 12 ns period
   localparam int RESET_CYCLES   = 12;
   localparam int PHASE_ITEMS    = 257;   // random ticks per register setting
   localparam int SWAP_IDLE_AT   = 350;   // sender busy, receiver lazy until here
   localparam int STOP_IDLE_AT   = 700;   // then the other way round, then no idling
   localparam int STALL_AT       = 760;   // long receiver hold-off starts here
   localparam int STALL_CYCLES   = 48;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
   localparam int CSR_WIDTH      = kmds_pkg::CSR_INDEX_WIDTH;

   localparam logic [CSR_WIDTH-1:0] CSR_FIRST_UNUSED =
      kmds_pkg::CSR_COUNT_RESTART + 1'b1;

   // Directed scan ticks, one scenario per line group
   localparam logic [15:0] DIRECTED [25] = '{
      // digit 1: confirm on two samples, fire while held, release on two samples
      16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000,
      // every key fires in the same tick: ten digit events, later key wins
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
      // one-sample bounce on D never confirms
      16'h8000, 16'h0000,
      // star: bounce during release returns to held
      16'h1000, 16'h1000, 16'h1000, 16'h0000, 16'h1000, 16'h0000, 16'h0000,
      // digit 0 released on the very tick it fires
      16'h2000, 16'h2000, 16'h0000, 16'h0000,
      // alternating patterns only ever arm
      16'hAAAA, 16'h5555
   };

   // Register settings for the later random phases: top extremes, a counter that
   // wraps through 255 before restarting, and bottom extremes.
   localparam logic [7:0] WRAP_SETTING    [3] = '{8'd255, 8'd3,   8'd0};
   localparam logic [7:0] RESTART_SETTING [3] = '{8'd255, 8'd250, 8'd0};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [15:0]          req_keys_pressed;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [3:0]           rsp_last_digit;
   logic [3:0]           rsp_last_symbol;
   logic [7:0]           rsp_digit_count;
   logic                 rsp_digit_event;
   logic                 rsp_symbol_event;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_index;
   logic [7:0]           csr_wdata;

   int          fail_count;
   int          pending_count;
   int          sent_count;
   int          send_idle_pct;
   int          take_idle_pct;
   int          quiet_cycles;
   bit          stall_done;
   logic [15:0] key_level;   // debounced intent: which keys the "user" holds

   keypad_matrix_debounce_scanner i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_keys_pressed (req_keys_pressed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_last_digit   (rsp_last_digit),
      .rsp_last_symbol  (rsp_last_symbol),
      .rsp_digit_count  (rsp_digit_count),
      .rsp_digit_event  (rsp_digit_event),
      .rsp_symbol_event (rsp_symbol_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   kmds_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_keys_pressed (req_keys_pressed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_last_digit   (rsp_last_digit),
      .rsp_last_symbol  (rsp_last_symbol),
      .rsp_digit_count  (rsp_digit_count),
      .rsp_digit_event  (rsp_digit_event),
      .rsp_symbol_event (rsp_symbol_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Next random scan tick. Mostly keys held for several ticks at a time so the
   // debouncers get through confirm, fire and release; the rest is contact
   // bounce on one key, line noise, and all-keys bursts that make many keys
   // fire together.
   function automatic logic [15:0] next_scan();
      logic [15:0] scan;
      int          roll;
      roll = $urandom_range(99, 0);
      if (roll < 3) key_level = '1;
      else if (roll < 6) key_level = '0;
      else begin
         for (int k = 0; k < kmds_pkg::KEY_COUNT; k++)
            if ($urandom_range(5, 0) == 0) key_level[k] = ~key_level[k];
      end
      scan = key_level;
      roll = $urandom_range(99, 0);
      if (roll < 10) scan[$urandom_range(15, 0)] ^= 1'b1;
      else if (roll < 15) scan = 16'($urandom);
      return scan;
   endfunction

   // Offer one scan tick; called and returning at a falling edge.
   task automatic send_tick(input logic [15:0] keys);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_keys_pressed <= keys;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      // swap idling roles, then stop idling altogether
      if (sent_count >= STOP_IDLE_AT) begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end else if (sent_count >= SWAP_IDLE_AT) begin
         send_idle_pct = 75;
         take_idle_pct = 23;
      end
      @(negedge clock);
   endtask

   // Write one register; leaves csr_valid high so back-to-back writes need no gap.
   task automatic write_reg(input logic [CSR_WIDTH-1:0] index,
                            input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold-off while the sender
   // keeps going so both pipeline stages fill and req_ready drops.
   initial begin
      rsp_ready  = 1'b0;
      stall_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_done && sent_count >= STALL_AT) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end else
            rsp_ready <= ($urandom_range(99, 0) >= take_idle_pct);
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_keys_pressed = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      key_level        = '0;
      sent_count       = 0;
      send_idle_pct    = 23;
      take_idle_pct    = 75;

      // hold reset, then release it on a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed ticks under the reset register values
      foreach (DIRECTED[i]) send_tick(DIRECTED[i]);

      // first random phase keeps the reset register values
      for (int i = 0; i < PHASE_ITEMS; i++) send_tick(next_scan());

      for (int p = 0; p < 3; p++) begin
         // registers change only with the block drained
         wait_idle();
         // an unmapped index must leave both registers alone
         if (p == 0)
            write_reg(CSR_WIDTH'($urandom_range(2 ** CSR_WIDTH - 1, CSR_FIRST_UNUSED)),
                      8'($urandom));
         write_reg(kmds_pkg::CSR_COUNT_WRAP_AT, WRAP_SETTING[p]);
         write_reg(kmds_pkg::CSR_COUNT_RESTART, RESTART_SETTING[p]);
         csr_valid <= 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) send_tick(next_scan());
      end

      wait_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[keypad_matrix_debounce_scanner.f]
+incdir+rtl
rtl/kmds_pkg.sv
rtl/kmds_key_debounce.sv
rtl/kmds_event_merge.sv
rtl/keypad_matrix_debounce_scanner.sv
bench/kmds_checker.sv
bench/keypad_matrix_debounce_scanner_tb.sv
